/* sv/skbi_pkg.sv */
`timescale 1ns / 1ps

package skbi_pkg;

    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 3;
    localparam int LENGTH_W = 32;
    localparam int HASH_W   = 32;
    localparam int TSIZE_W  = 25;

    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 25'd2;
    localparam logic [TSIZE_W-1:0] TSIZE_MIN   = 25'd2;

    // avalanche shift amounts, in step order
    localparam int AV_S0 = 3;
    localparam int AV_S1 = 5;
    localparam int AV_S2 = 4;
    localparam int AV_S3 = 17;
    localparam int AV_S4 = 25;
    localparam int AV_S5 = 6;

    localparam int AV_STEPS = 6;
    localparam int STEP_W   = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AVAL,
        ST_DIV,
        ST_WAIT
    } skbi_state_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } skbi_div_stat_t;

endpackage

/* sv/skbi_if.sv */
`timescale 1ns / 1ps

interface skbi_key_if;
    import skbi_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    key_bytes;
    logic [COUNT_W-1:0]  byte_count;
    logic [LENGTH_W-1:0] key_length;
    logic                first_chunk;
    logic                last_chunk;

    modport source (
        output valid, key_bytes, byte_count, key_length, first_chunk, last_chunk,
        input  ready
    );
    modport sink (
        input  valid, key_bytes, byte_count, key_length, first_chunk, last_chunk,
        output ready
    );
endinterface

interface skbi_hash_if #(
    parameter int INDEX_WIDTH = 24
);
    import skbi_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] bucket_index;
    logic [HASH_W-1:0]      raw_hash;

    modport source (
        output valid, bucket_index, raw_hash,
        input  ready
    );
    modport sink (
        input  valid, bucket_index, raw_hash,
        output ready
    );
endinterface

interface skbi_cfg_if;
    import skbi_pkg::*;

    logic               valid;
    logic               ready;
    logic [TSIZE_W-1:0] table_size;

    modport source (
        output valid, table_size,
        input  ready
    );
    modport sink (
        input  valid, table_size,
        output ready
    );
endinterface

/* sv/skbi_divider.sv */
`timescale 1ns / 1ps

module skbi_divider #(
    parameter int DIVISOR_WIDTH = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [skbi_pkg::HASH_W-1:0]  dividend,
    input  logic [DIVISOR_WIDTH-1:0]     divisor,
    output skbi_pkg::skbi_div_stat_t     stat,
    output logic [DIVISOR_WIDTH-1:0]     remainder
);
    import skbi_pkg::*;

    localparam int REM_W = DIVISOR_WIDTH + 1;
    localparam int CNT_W = $clog2(HASH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [HASH_W-1:0]        dvd_reg, dvd_next;
    logic [DIVISOR_WIDTH-1:0] dsr_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [REM_W-1:0]         shifted;
    logic [REM_W-1:0]         dsr_ext;

    // one restoring step per cycle, msb of the dividend first
    always_comb
    begin
        shifted  = {rem_reg[REM_W-2:0], dvd_reg[HASH_W-1]};
        dsr_ext  = {1'b0, dsr_reg};
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = (shifted >= dsr_ext) ? (shifted - dsr_ext) : shifted;
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg[DIVISOR_WIDTH-1:0];

endmodule

/* sv/string_key_hash_bucket_index_unit.sv */
`timescale 1ns / 1ps

// string key hash to bucket index
// key_in: one transfer per 4-byte little-endian chunk of a key; first_chunk
//   seeds the hash with key_length, last_chunk closes the key
// hash_out: one transfer per key, bucket_index = raw_hash mod table size
// cfg: writes table_size (clamped to 2 .. 2^INDEX_WIDTH), ready is always high;
//   write it only while no key is in flight
// a chunk that is not last is mixed into the running hash and key_in stays ready
// a last chunk holds key_in through its own transfer, the avalanche steps of the
//   shared shift/xor/add step, the one-bit-per-cycle restoring divider, a
//   hand-over and the load of the output register, which waits while a
//   previous result is still stalled on hash_out
// key_in is not ready from the last chunk until the result sits in the
//   output register
// the output register parts the two sides: chunks of the next key are taken
//   while a result waits; if hash_out stalls, the next result holds in the
//   wait state until the register frees up
// reset: sequencer idle, running hash 0, table_size 2, no result pending
module string_key_hash_bucket_index_unit #(
    parameter int INDEX_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    skbi_key_if.sink    key_in,
    skbi_hash_if.source hash_out,
    skbi_cfg_if.sink    cfg
);
    import skbi_pkg::*;

    // divisor wide enough for 2^INDEX_WIDTH
    localparam int SIZE_W = INDEX_WIDTH + 1;
    localparam int CMP_W  = (SIZE_W > TSIZE_W) ? SIZE_W : TSIZE_W;
    localparam logic [CMP_W-1:0] SIZE_CAP = CMP_W'(1) << INDEX_WIDTH;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(AV_STEPS - 1);

    // sign-extend one key byte
    function automatic logic [HASH_W-1:0] sext_byte(input logic [7:0] b);
        sext_byte = {{(HASH_W - 8){b[7]}}, b};
    endfunction

    // chunk mixing, combinational
    function automatic logic [HASH_W-1:0] mix_chunk(
        input logic [HASH_W-1:0]  h_in,
        input logic [KEY_W-1:0]   data,
        input logic [COUNT_W-1:0] count
    );
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] t;
        h = h_in;
        case (count) inside
            3'd4, 3'd5, 3'd6, 3'd7:
            begin
                h = h + {16'd0, data[15:0]};
                t = {5'd0, data[31:16], 11'd0} ^ h;
                h = {h[15:0], 16'd0} ^ t;
                h = h + (h >> 11);
            end
            3'd3:
            begin
                h = h + {16'd0, data[15:0]};
                h = h ^ (h << 16);
                h = h ^ (sext_byte(data[23:16]) << 18);
                h = h + (h >> 11);
            end
            3'd2:
            begin
                h = h + {16'd0, data[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            3'd1:
            begin
                h = h + sext_byte(data[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        mix_chunk = h;
    endfunction

    // shared avalanche step: xor with left shift or add of right shift
    function automatic logic [HASH_W-1:0] aval_step(
        input logic [HASH_W-1:0] h,
        input logic [STEP_W-1:0] idx
    );
        case (idx)
            3'd0:    aval_step = h ^ (h << AV_S0);
            3'd1:    aval_step = h + (h >> AV_S1);
            3'd2:    aval_step = h ^ (h << AV_S2);
            3'd3:    aval_step = h + (h >> AV_S3);
            3'd4:    aval_step = h ^ (h << AV_S4);
            default: aval_step = h + (h >> AV_S5);
        endcase
    endfunction

    skbi_state_t state_reg, state_next;

    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [TSIZE_W-1:0]     tsize_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_WIDTH-1:0] bucket_reg;
    logic [HASH_W-1:0]      raw_reg;
    logic                   load_out;

    logic                   in_xfer;
    logic                   empty_key;
    logic [HASH_W-1:0]      seed;
    logic [HASH_W-1:0]      aval_out;
    logic                   div_start;
    logic [CMP_W-1:0]       tsize_ext;
    logic [CMP_W-1:0]       size_clamp;
    logic [SIZE_W-1:0]      size_eff;
    skbi_div_stat_t         div_stat;
    logic [SIZE_W-1:0]      div_rem;

    // handshakes
    assign key_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign in_xfer      = key_in.valid && key_in.ready;

    assign hash_out.valid        = out_valid_reg;
    assign hash_out.bucket_index = bucket_reg;
    assign hash_out.raw_hash     = raw_reg;

    // effective bucket count
    always_comb
    begin
        tsize_ext  = CMP_W'(tsize_reg);
        size_clamp = tsize_ext;
        if (tsize_ext < CMP_W'(TSIZE_MIN))
        begin
            size_clamp = CMP_W'(TSIZE_MIN);
        end
        else if (tsize_ext > SIZE_CAP)
        begin
            size_clamp = SIZE_CAP;
        end
        size_eff = size_clamp[SIZE_W-1:0];
    end

    assign empty_key = key_in.first_chunk && key_in.last_chunk && (key_in.key_length == '0);
    assign seed      = key_in.first_chunk ? key_in.key_length : hash_reg;
    assign aval_out  = aval_step(hash_reg, step_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        step_next      = step_reg;
        div_start      = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg;
        if (hash_out.valid && hash_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (empty_key)
                    begin
                        // avalanche and modulo of zero both give zero
                        hash_next  = '0;
                        step_next  = '0;
                        state_next = ST_AVAL;
                    end
                    else
                    begin
                        hash_next = mix_chunk(seed, key_in.key_bytes, key_in.byte_count);
                        if (key_in.last_chunk)
                        begin
                            step_next  = '0;
                            state_next = ST_AVAL;
                        end
                    end
                end
            end
            ST_AVAL:
            begin
                hash_next = aval_out;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!out_valid_reg || hash_out.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    hash_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            step_reg      <= '0;
            tsize_reg     <= TSIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                tsize_reg <= cfg.table_size;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            bucket_reg <= div_rem[INDEX_WIDTH-1:0];
            raw_reg    <= hash_reg;
        end
    end

    // shared modulo unit, dividend latched at start
    skbi_divider #(
        .DIVISOR_WIDTH (SIZE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (aval_out),
        .divisor   (size_eff),
        .stat      (div_stat),
        .remainder (div_rem)
    );

endmodule

/* sv/skbi_checker.sv */
`timescale 1ns / 1ps

module skbi_checker #(
    parameter int INDEX_WIDTH = 24
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_last,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [INDEX_WIDTH-1:0] out_index,
    input logic [31:0]            out_raw
);

    // a pending result holds until transferred
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_index) && $stable(out_raw));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result dropped or changed while stalled");

    // closing a key stops chunk intake while the hash finishes
    property p_last_blocks;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready;
    endproperty
    a_last_blocks: assert property (p_last_blocks)
        else $error("chunk intake open right after a last chunk");

    // a chunk in the middle of a key keeps chunk intake open in the cycle after it
    property p_mid_chunk;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_last) |=> in_ready;
    endproperty
    a_mid_chunk: assert property (p_mid_chunk)
        else $error("intake stalled after a middle chunk");

    // zero hash always lands in bucket zero
    property p_zero_bucket;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (out_raw == 32'd0)) |-> (out_index == '0);
    endproperty
    a_zero_bucket: assert property (p_zero_bucket)
        else $error("zero hash mapped to a nonzero bucket");

endmodule

bind string_key_hash_bucket_index_unit skbi_checker #(
    .INDEX_WIDTH (INDEX_WIDTH)
) u_skbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (key_in.valid),
    .in_ready  (key_in.ready),
    .in_last   (key_in.last_chunk),
    .out_valid (hash_out.valid),
    .out_ready (hash_out.ready),
    .out_index (hash_out.bucket_index),
    .out_raw   (hash_out.raw_hash)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

// chunk stream in, one bucket index per key out; expectations come from a
// bit-true model of the hash kept inside this module, or are typed into directed rows
module testbench;
    import skbi_pkg::*;

    localparam int IDX_W      = 24;
    localparam int TAIL_WAIT  = 60;      // settle time after the last owed result is back
    localparam int DRAIN_MAX  = 20000;
    localparam int HOLD_LONG  = 400;     // receiver hold-off, fills the block up
    localparam int PHASE_LEN  = 80;      // chunks per random phase
    localparam int N_PHASES   = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key_bytes;
        logic [COUNT_W-1:0]  byte_count;
        logic [LENGTH_W-1:0] key_length;
        logic                first_chunk;
        logic                last_chunk;
    } chunk_t;

    typedef struct packed {
        logic [IDX_W-1:0]  bucket_index;
        logic [HASH_W-1:0] raw_hash;
    } bucket_t;

    // one directed row: a chunk, and a typed-in result where it is obvious
    typedef struct packed {
        chunk_t  chunk;
        logic    typed;
        bucket_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    skbi_key_if                          key_bus ();
    skbi_hash_if #(.INDEX_WIDTH(IDX_W))  hash_bus ();
    skbi_cfg_if                          cfg_bus ();

    string_key_hash_bucket_index_unit #(
        .INDEX_WIDTH(IDX_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   (key_bus),
        .hash_out (hash_bus),
        .cfg      (cfg_bus)
    );

    // model state: hash carried between chunks of a key, and the bucket count
    logic [HASH_W-1:0]  chain_hash;
    logic [TSIZE_W-1:0] bucket_cfg;

    // results still owed by the block, oldest first
    bucket_t buckets_owed[$];

    // typed-in result that travels with the chunk on the bus
    logic    stim_typed;
    bucket_t stim_typed_want;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int errors;

    dir_row_t directed_rows [25];

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // hash model
    // ------------------------------------------------------------------

    // odd tail byte counts as a signed char
    function automatic logic [31:0] widen_signed_byte(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // one chunk of the mixing loop, or the tail step for 1..3 bytes
    function automatic logic [31:0] mix_in_chunk(input logic [31:0] h,
                                                 input logic [31:0] d,
                                                 input logic [2:0]  n);
        logic [31:0] t;
        logic [2:0]  cnt;
        cnt = (n > 3'd4) ? 3'd4 : n;
        case (cnt)
            3'd4:
            begin
                h = h + {16'd0, d[15:0]};
                t = ({16'd0, d[31:16]} << 11) ^ h;
                h = (h << 16) ^ t;
                h = h + (h >> 11);
            end
            3'd3:
            begin
                h = h + {16'd0, d[15:0]};
                h = h ^ (h << 16);
                h = h ^ (widen_signed_byte(d[23:16]) << 18);
                h = h + (h >> 11);
            end
            3'd2:
            begin
                h = h + {16'd0, d[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            3'd1:
            begin
                h = h + widen_signed_byte(d[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
            end
        endcase
        return h;
    endfunction

    function automatic logic [31:0] avalanche_hash(input logic [31:0] h);
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    // advance the key hash by one chunk; returns 1 when the chunk closes a key
    function automatic bit hash_chunk(input chunk_t c, output bucket_t r);
        logic [31:0]     h;
        longint unsigned nb;
        r = '0;
        // empty key: both flags and zero length, nothing is mixed
        if (c.first_chunk && c.last_chunk && c.key_length == '0)
        begin
            chain_hash = '0;
            return 1'b1;
        end
        h = c.first_chunk ? c.key_length : chain_hash;
        h = mix_in_chunk(h, c.key_bytes, c.byte_count);
        if (!c.last_chunk)
        begin
            chain_hash = h;
            return 1'b0;
        end
        h = avalanche_hash(h);
        chain_hash = '0;
        // bucket count clamps to 2 .. 2^IDX_W
        nb = longint'(bucket_cfg);
        if (nb < 64'd2)
            nb = 64'd2;
        if (nb > (64'd1 << IDX_W))
            nb = 64'd1 << IDX_W;
        r.raw_hash     = h;
        r.bucket_index = IDX_W'(longint'(h) % nb);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // monitor: model update on every input transfer, check on every output
    // transfer; all values are sampled before the edge takes effect
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        bucket_t got_want;
        chunk_t  c;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                bucket_cfg = cfg_bus.table_size;
            if (key_bus.valid && key_bus.ready)
            begin
                c.key_bytes   = key_bus.key_bytes;
                c.byte_count  = key_bus.byte_count;
                c.key_length  = key_bus.key_length;
                c.first_chunk = key_bus.first_chunk;
                c.last_chunk  = key_bus.last_chunk;
                if (hash_chunk(c, got_want))
                begin
                    if (stim_typed)
                        got_want = stim_typed_want;
                    buckets_owed.push_back(got_want);
                end
            end
            if (hash_bus.valid && hash_bus.ready)
            begin
                if (buckets_owed.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result bucket_index %h raw_hash %h",
                             $time, hash_bus.bucket_index, hash_bus.raw_hash);
                end
                else
                begin
                    got_want = buckets_owed.pop_front();
                    if (hash_bus.bucket_index !== got_want.bucket_index)
                    begin
                        errors++;
                        $display("%0t: bucket_index expected %h actual %h",
                                 $time, got_want.bucket_index, hash_bus.bucket_index);
                    end
                    if (hash_bus.raw_hash !== got_want.raw_hash)
                    begin
                        errors++;
                        $display("%0t: raw_hash expected %h actual %h",
                                 $time, got_want.raw_hash, hash_bus.raw_hash);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        hash_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                hash_bus.ready <= 1'b0;
            end
            else
                hash_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one chunk, with random idle cycles ahead of it, until it transfers
    task automatic send_chunk(input chunk_t c, input logic typed, input bucket_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            key_bus.valid <= 1'b0;
            @(posedge clk);
        end
        key_bus.valid       <= 1'b1;
        key_bus.key_bytes   <= c.key_bytes;
        key_bus.byte_count  <= c.byte_count;
        key_bus.key_length  <= c.key_length;
        key_bus.first_chunk <= c.first_chunk;
        key_bus.last_chunk  <= c.last_chunk;
        stim_typed          <= typed;
        stim_typed_want     <= want;
        @(posedge clk);
        while (!key_bus.ready)
            @(posedge clk);
    endtask

    // wait until every owed result is back, then let the back end settle
    task automatic drain_results();
        int guard;
        guard = 0;
        while (buckets_owed.size() != 0 && guard < DRAIN_MAX)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    // close any open key with an empty one, go idle, then write the register
    task automatic write_table_size(input logic [TSIZE_W-1:0] v);
        chunk_t c;
        c = '{key_bytes: '0, byte_count: '0, key_length: '0,
              first_chunk: 1'b1, last_chunk: 1'b1};
        send_chunk(c, 1'b0, '0);
        key_bus.valid <= 1'b0;
        drain_results();
        cfg_bus.valid      <= 1'b1;
        cfg_bus.table_size <= v;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly well-formed keys with random content, some noise chunks
    task automatic run_random_phase(input int n_chunks);
        chunk_t c;
        int     sent;
        int     len;
        int     nch;
        int     n_noise;
        sent = 0;
        while (sent < n_chunks)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 0);
                nch = (len == 0) ? 1 : (len + 3) / 4;
                for (int i = 0; i < nch; i++)
                begin
                    c.key_bytes   = $urandom;
                    c.byte_count  = (len == 0) ? 3'd0 : ((i == nch - 1) ? 3'(len - 4 * i) : 3'd4);
                    // length only matters on the first chunk, so junk elsewhere
                    c.key_length  = (i == 0) ? 32'(len) : $urandom;
                    c.first_chunk = (i == 0);
                    c.last_chunk  = (i == nch - 1);
                    send_chunk(c, 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                n_noise = $urandom_range(3, 1);
                for (int i = 0; i < n_noise; i++)
                begin
                    c.key_bytes   = $urandom;
                    c.byte_count  = 3'($urandom_range(7, 0));
                    case ($urandom_range(2))
                        0:       c.key_length = '0;
                        1:       c.key_length = $urandom;
                        default: c.key_length = $urandom_range(40);
                    endcase
                    c.first_chunk = 1'($urandom_range(1));
                    c.last_chunk  = 1'($urandom_range(1));
                    send_chunk(c, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        logic [TSIZE_W-1:0] size_plan [N_PHASES];
        idle_mode_t         mode;

        clk                 = 1'b0;
        rst_n              <= 1'b0;
        key_bus.valid      <= 1'b0;
        key_bus.key_bytes  <= '0;
        key_bus.byte_count <= '0;
        key_bus.key_length <= '0;
        key_bus.first_chunk <= 1'b0;
        key_bus.last_chunk <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.table_size <= '0;
        stim_typed         <= 1'b0;
        stim_typed_want    <= '0;
        chain_hash          = '0;
        bucket_cfg          = TSIZE_RESET;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_left           = 0;
        errors              = 0;

        // directed rows; typed results only where the answer is plainly zero
        directed_rows = '{
            // empty key
            '{'{32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1, 1'b1}, 1'b1, '{24'd0, 32'd0}},
            // zero count from a cleared hash, data ignored
            '{'{32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b1, '{24'd0, 32'd0}},
            // all-zero full chunk from a cleared hash
            '{'{32'h0000_0000, 3'd4, 32'h0000_0000, 1'b0, 1'b1}, 1'b1, '{24'd0, 32'd0}},
            '{'{32'h6463_6261, 3'd4, 32'd4,         1'b1, 1'b1}, 1'b0, '0},
            // one-byte tails, negative and positive odd byte
            '{'{32'h0000_0080, 3'd1, 32'd1,         1'b1, 1'b1}, 1'b0, '0},
            '{'{32'h0000_007F, 3'd1, 32'd1,         1'b1, 1'b1}, 1'b0, '0},
            '{'{32'h0000_FFFF, 3'd2, 32'd2,         1'b1, 1'b1}, 1'b0, '0},
            // three-byte tails, odd byte sign-extended
            '{'{32'h00FF_FFFF, 3'd3, 32'd3,         1'b1, 1'b1}, 1'b0, '0},
            '{'{32'h007F_1234, 3'd3, 32'd3,         1'b1, 1'b1}, 1'b0, '0},
            // counts above four act as four
            '{'{32'hFFFF_FFFF, 3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '0},
            '{'{32'hFFFF_FFFF, 3'd6, 32'd7,         1'b1, 1'b1}, 1'b0, '0},
            '{'{32'hA5A5_A5A5, 3'd7, 32'd8,         1'b1, 1'b1}, 1'b0, '0},
            // empty-key flags win over a full chunk
            '{'{32'hDEAD_BEEF, 3'd4, 32'h0000_0000, 1'b1, 1'b1}, 1'b1, '{24'd0, 32'd0}},
            // ten-byte key in three chunks, length ignored after the first
            '{'{32'h0302_0100, 3'd4, 32'd10,        1'b1, 1'b0}, 1'b0, '0},
            '{'{32'h0706_0504, 3'd4, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0908, 3'd2, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, '0},
            // short chunk that is not last, key goes on
            '{'{32'h0000_00C3, 3'd1, 32'd5,         1'b1, 1'b0}, 1'b0, '0},
            '{'{32'h1122_3344, 3'd4, 32'd0,         1'b0, 1'b1}, 1'b0, '0},
            // no first flag after a finished key, starts from zero
            '{'{32'hCAFE_F00D, 3'd4, 32'd123,       1'b0, 1'b0}, 1'b0, '0},
            '{'{32'h0BAD_F00D, 3'd3, 32'd0,         1'b0, 1'b1}, 1'b0, '0},
            // first flag in the middle of a key reseeds
            '{'{32'h1234_5678, 3'd4, 32'd8,         1'b1, 1'b0}, 1'b0, '0},
            '{'{32'h9ABC_DEF0, 3'd4, 32'd4,         1'b1, 1'b1}, 1'b0, '0},
            // zero length on a key that does not close at once is not empty
            '{'{32'hFFFF_FFFF, 3'd4, 32'd0,         1'b1, 1'b0}, 1'b0, '0},
            '{'{32'hFFFF_FFFF, 3'd4, 32'd0,         1'b0, 1'b1}, 1'b0, '0},
            // seed alone, zero count
            '{'{32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '0}
        };

        // bucket counts per phase: below the floor, above the cap, extremes
        size_plan = '{25'd0, 25'd3, 25'h1FF_FFFF, 25'd1, 25'h100_0000,
                      25'd1000003, 25'h100_0001, 25'd65536, 25'd16777213, 25'd2};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset bucket count of 2, no idling
        foreach (directed_rows[i])
            send_chunk(directed_rows[i].chunk, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_table_size(size_plan[p]);
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                IDLE_SEND:
                begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                IDLE_RECV:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            // long receiver hold-off while the sender keeps offering chunks
            if (p == 0 || p == 7)
                hold_left = HOLD_LONG;
            run_random_phase(PHASE_LEN);
        end

        key_bus.valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();

        if (buckets_owed.size() != 0)
        begin
            errors += buckets_owed.size();
            $display("%0t: %0d results never arrived", $time, buckets_owed.size());
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
